@@ hw/rtl/hsv_to_rgb_converter_defines.svh @@
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared property wrappers for the converter's checker.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Concurrent property, sampled on the rising clock, off while reset is low.
`define HSVRGB_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("hsv_to_rgb_converter: property violated");

// Condition that must never be true at a clock edge outside reset.
`define HSVRGB_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("hsv_to_rgb_converter: forbidden condition seen");

`endif

@@ hw/rtl/hsvrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Fixed-point constants, channel selection codes and helper functions.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	// Full scale of an input component (maps to 1.0 or 360 degrees)
	localparam logic [7:0]  FULL_SCALE = 8'd254;
	// FULL_SCALE squared
	localparam logic [23:0] SCALE_SQ   = 24'd64516;
	// FULL_SCALE cubed, the divisor of the final byte scaling
	localparam logic [31:0] DEN        = 32'd16387064;
	// Half of DEN, for rounding to nearest
	localparam logic [31:0] HALF_DEN   = 32'd8193532;
	// floor(2^38 / DEN): reciprocal used on numerator bits [31:14]
	localparam logic [14:0] RECIP      = 15'd16774;
	localparam int          RECIP_SHIFT = 24;

	// What a channel receives before the offset is added
	typedef logic [1:0] sel_t;
	localparam sel_t SEL_C    = 2'd0;   // chroma
	localparam sel_t SEL_X    = 2'd1;   // second component
	localparam sel_t SEL_ZERO = 2'd2;   // nothing

	typedef struct packed {
		sel_t r;
		sel_t g;
		sel_t b;
	} sel_set_t;

	// Sector 6 only occurs for hue at 360 degrees and behaves like sector 5
	function automatic sel_set_t sector_sel(input logic [2:0] sector);
		sel_set_t s;
		unique case (sector)
			3'd0: s = '{r: SEL_C,    g: SEL_X,    b: SEL_ZERO};
			3'd1: s = '{r: SEL_X,    g: SEL_C,    b: SEL_ZERO};
			3'd2: s = '{r: SEL_ZERO, g: SEL_C,    b: SEL_X};
			3'd3: s = '{r: SEL_ZERO, g: SEL_X,    b: SEL_C};
			3'd4: s = '{r: SEL_X,    g: SEL_ZERO, b: SEL_C};
			default: s = '{r: SEL_C, g: SEL_ZERO, b: SEL_X};
		endcase
		return s;
	endfunction

	// Amount taken off v*254^2 for a channel: chroma needs nothing, the second
	// component loses v*s*dist, an empty channel loses the whole chroma v*s*254
	function automatic logic [23:0] pick_sub(input sel_t sel, input logic [23:0] p_dist,
			input logic [23:0] p_full);
		logic [23:0] r;
		unique case (sel)
			SEL_C:    r = '0;
			SEL_X:    r = p_dist;
			SEL_ZERO: r = p_full;
			default:  r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/hsvrgb_byte_scale.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB byte scaler
// Three-stage pipe: forms 255 * (a - b) + DEN/2 and divides it by DEN = 254^3
// through a reciprocal estimate and one correction step.
// ----------------------------------------------------------------------------
module hsvrgb_byte_scale import hsvrgb_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [23:0] minuend,
	input  logic [23:0] subtrahend,
	output logic [7:0]  level
);

	logic [23:0] val3;
	logic [31:0] num;
	logic [32:0] est_prod;
	logic [31:0] q_times_den;
	logic [31:0] rem;

	logic [31:0] num_s3;
	logic [31:0] num_s4;
	logic [7:0]  est_s4;
	logic [7:0]  level_s5;

	// 255 * val3 as a shift and subtract, then add half of the divisor
	assign val3 = minuend - subtrahend;
	assign num  = ({val3, 8'b0} - {8'b0, val3}) + HALF_DEN;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= num;
		end
	end

	// Estimate is never high and at most one low
	assign est_prod = 33'(num_s3[31:14]) * 33'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= num_s3;
			est_s4 <= est_prod[RECIP_SHIFT +: 8];
		end
	end

	assign q_times_den = 32'(est_s4) * DEN;
	assign rem         = num_s4 - q_times_den;

	always_ff @(posedge clk) begin
		if (en) begin
			level_s5 <= (rem >= DEN) ? est_s4 + 8'd1 : est_s4;
		end
	end

	assign level = level_s5;

endmodule

@@ hw/rtl/hsv_to_rgb_converter.sv @@
// Throughput: one color per cycle unless frozen; stage 1 (sector and
//   distance), stage 2 (products), stages 3 to 5 (byte scaling by
//   255/254^3) all take one item, and each stage is registered.
// A stalled, valid result freezes the whole pipe; the input stalls only then.
// Reset clears the five stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts hue, saturation and value (0..254) to red, green and blue bytes.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter import hsvrgb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       hsv_valid,
	output logic       hsv_stall,
	input  logic [7:0] hue_in,
	input  logic [7:0] saturation_in,
	input  logic [7:0] value_in,
	output logic       rgb_valid,
	input  logic       rgb_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);

	logic en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic [7:0]  hue_c, sat_c, val_c;
	logic [10:0] six_h;
	logic [2:0]  sector;
	logic [10:0] pair_base;
	logic [10:0] pos;
	logic [7:0]  hue_dist;

	logic [2:0]  sector_s1;
	logic [7:0]  dist_s1;
	logic [15:0] prod_s1;
	logic [23:0] vfull_s1;

	sel_set_t    sel_s2;
	logic [23:0] p_dist_s2;
	logic [23:0] p_full_s2;
	logic [23:0] vfull_s2;

	// Advance unless a finished result is held on the output
	assign en        = !(vld_s5 && rgb_stall);
	assign hsv_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= hsv_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage 1: clamp inputs, find the sector and the distance from its middle
	assign hue_c = (hue_in > FULL_SCALE) ? FULL_SCALE : hue_in;
	assign sat_c = (saturation_in > FULL_SCALE) ? FULL_SCALE : saturation_in;
	assign val_c = (value_in > FULL_SCALE) ? FULL_SCALE : value_in;

	assign six_h = {1'b0, hue_c, 2'b0} + {2'b0, hue_c, 1'b0};

	always_comb begin
		sector = 3'd0;
		if (six_h >= 11'd254)  sector = 3'd1;
		if (six_h >= 11'd508)  sector = 3'd2;
		if (six_h >= 11'd762)  sector = 3'd3;
		if (six_h >= 11'd1016) sector = 3'd4;
		if (six_h >= 11'd1270) sector = 3'd5;
		if (six_h >= 11'd1524) sector = 3'd6;
	end

	// Start of the sector pair: 508 times sector / 2
	always_comb begin
		unique case (sector[2:1])
			2'd0: pair_base = 11'd0;
			2'd1: pair_base = 11'd508;
			2'd2: pair_base = 11'd1016;
			2'd3: pair_base = 11'd1524;
			default: pair_base = 11'd0;
		endcase
	end

	assign pos      = six_h - pair_base;
	assign hue_dist = (pos >= 11'(FULL_SCALE)) ? 8'(pos - 11'(FULL_SCALE))
			: 8'(11'(FULL_SCALE) - pos);

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s1 <= sector;
			dist_s1   <= hue_dist;
			prod_s1   <= 16'(sat_c) * 16'(val_c);
			vfull_s1  <= 24'(val_c) * SCALE_SQ;
		end
	end

	// Stage 2: scale v*s by the distance and by full scale, route per channel
	always_ff @(posedge clk) begin
		if (en) begin
			sel_s2    <= sector_sel(sector_s1);
			p_dist_s2 <= 24'(prod_s1) * 24'(dist_s1);
			p_full_s2 <= 24'(prod_s1) * 24'(FULL_SCALE);
			vfull_s2  <= vfull_s1;
		end
	end

	// Stages 3 to 5: each channel is v*254^2 minus its share, scaled to a byte
	hsvrgb_byte_scale u_red (
		.clk        (clk),
		.en         (en),
		.minuend    (vfull_s2),
		.subtrahend (pick_sub(sel_s2.r, p_dist_s2, p_full_s2)),
		.level      (red_out)
	);

	hsvrgb_byte_scale u_green (
		.clk        (clk),
		.en         (en),
		.minuend    (vfull_s2),
		.subtrahend (pick_sub(sel_s2.g, p_dist_s2, p_full_s2)),
		.level      (green_out)
	);

	hsvrgb_byte_scale u_blue (
		.clk        (clk),
		.en         (en),
		.minuend    (vfull_s2),
		.subtrahend (pick_sub(sel_s2.b, p_dist_s2, p_full_s2)),
		.level      (blue_out)
	);

	assign rgb_valid = vld_s5;

endmodule

@@ hw/rtl/hsvrgb_checker.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Port-level properties of the converter, attached by bind.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_defines.svh"

module hsvrgb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       hsv_valid,
	input logic       hsv_stall,
	input logic [7:0] hue_in,
	input logic [7:0] saturation_in,
	input logic [7:0] value_in,
	input logic       rgb_valid,
	input logic       rgb_stall,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out
);

	// A held result stays offered with the same color
	`HSVRGB_ASSERT(a_out_hold, clk, arst_n, rgb_valid && rgb_stall |=> rgb_valid && $stable({red_out, green_out, blue_out}))

	// The input side only waits on a result that is held on the output
	`HSVRGB_NEVER(a_stall_cause, clk, arst_n, hsv_stall && !(rgb_valid && rgb_stall))

	// With no input transfer and no output stall, the pipe empties
	`HSVRGB_ASSERT(a_drain, clk, arst_n, (!hsv_valid && !rgb_stall) ##1 (!hsv_valid && !rgb_stall) ##1 (!hsv_valid && !rgb_stall) ##1 (!hsv_valid && !rgb_stall) ##1 (!hsv_valid && !rgb_stall) |=> !rgb_valid)

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (.*);

@@ tb/sv/tb_hsv_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Sends hue, saturation and value triples through the converter with random
// gaps on the input and random stalls on the output. Each output transfer is
// checked against an exact integer model of the color conversion.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_ITEMS = 2000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned MAX_REPORTS  = 10;

	localparam logic [31:0] FULL = 32'd254;

	// Hue sectors, 60 degrees each
	localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
	localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
	localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
	localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
	localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;

	// Pacing modes for gaps and stalls
	localparam int unsigned PACE_NONE  = 0;
	localparam int unsigned PACE_ANY   = 1;
	localparam int unsigned PACE_RARE  = 2;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] sat;
		logic [7:0] val;
		logic [3:0] gap;
	} hsv_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       hsv_valid = 1'b0;
	logic       hsv_stall;
	logic [7:0] hue_in = '0;
	logic [7:0] saturation_in = '0;
	logic [7:0] value_in = '0;
	logic       rgb_valid;
	logic       rgb_stall = 1'b0;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;

	hsv_item_t   hsv_pending[$];
	rgb_t        rgb_expected[$];
	int unsigned n_items = 0;
	int unsigned n_sent = 0;
	int unsigned n_results = 0;
	int unsigned n_errors = 0;
	int unsigned n_directed = 0;
	int unsigned n_cycles = 0;

	hsv_to_rgb_converter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.hsv_valid     (hsv_valid),
		.hsv_stall     (hsv_stall),
		.hue_in        (hue_in),
		.saturation_in (saturation_in),
		.value_in      (value_in),
		.rgb_valid     (rgb_valid),
		.rgb_stall     (rgb_stall),
		.red_out       (red_out),
		.green_out     (green_out),
		.blue_out      (blue_out)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Scale a value held in units of 1/254^3 to a byte, round half up, clamp
	function automatic logic [7:0] scale_to_byte(input logic [63:0] val3);
		logic [63:0] den;
		logic [63:0] r;
		den = FULL * FULL * FULL;
		r = (64'd255 * val3 + den / 2) / den;
		return (r > 64'd255) ? 8'd255 : r[7:0];
	endfunction

	function automatic rgb_t hsv_to_rgb_ref(input logic [7:0] h_raw, input logic [7:0] s_raw,
			input logic [7:0] v_raw);
		logic [31:0] h, s, v;
		logic [31:0] six_h, pos, hue_dist;
		logic [2:0]  sector;
		logic [63:0] chroma, second, offset;
		logic [63:0] r, g, b;
		rgb_t        res;
		h = (h_raw > FULL) ? FULL : {24'd0, h_raw};
		s = (s_raw > FULL) ? FULL : {24'd0, s_raw};
		v = (v_raw > FULL) ? FULL : {24'd0, v_raw};
		six_h    = 32'd6 * h;
		pos      = six_h % (2 * FULL);
		hue_dist = (pos >= FULL) ? pos - FULL : FULL - pos;
		sector   = 3'(six_h / FULL);
		chroma = 64'(v) * s * FULL;
		second = 64'(v) * s * (FULL - hue_dist);
		offset = 64'(v) * FULL * FULL - chroma;
		r = '0;
		g = '0;
		b = '0;
		case (sector)
			SEC_RED_YELLOW: begin
				r = chroma;
				g = second;
			end
			SEC_YELLOW_GREEN: begin
				r = second;
				g = chroma;
			end
			SEC_GREEN_CYAN: begin
				g = chroma;
				b = second;
			end
			SEC_CYAN_BLUE: begin
				g = second;
				b = chroma;
			end
			SEC_BLUE_MAGENTA: begin
				r = second;
				b = chroma;
			end
			// last sector, also hue at 360 degrees
			default: begin
				r = chroma;
				b = second;
			end
		endcase
		res.red   = scale_to_byte(r + offset);
		res.green = scale_to_byte(g + offset);
		res.blue  = scale_to_byte(b + offset);
		return res;
	endfunction

	function automatic int unsigned draw_wait(input int unsigned mode);
		case (mode)
			PACE_NONE: return 0;
			PACE_ANY:  return $urandom_range(0, 11);
			default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
		endcase
	endfunction

	// Mostly legal components, some at the edges, some above full scale
	function automatic logic [7:0] pick_component();
		int unsigned kind;
		kind = $urandom_range(0, 9);
		case (kind)
			0: begin
				case ($urandom_range(0, 5))
					0: return 8'd0;
					1: return 8'd1;
					2: return 8'd127;
					3: return 8'd253;
					4: return 8'd254;
					default: return 8'd255;
				endcase
			end
			1: return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(0, 254));
		endcase
	endfunction

	task automatic add_item(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v,
			input int unsigned gap);
		hsv_item_t it;
		it.hue = h;
		it.sat = s;
		it.val = v;
		it.gap = 4'(gap);
		hsv_pending.push_back(it);
	endtask

	// Input driver: one transfer per accepted item, gap drawn per item
	always @(posedge clk or negedge arst_n) begin : drive
		logic        next_valid;
		logic        armed;
		int unsigned wait_left;
		hsv_item_t   cur;
		if (!arst_n) begin
			hsv_valid <= 1'b0;
			armed = 1'b0;
			wait_left = 0;
		end else begin
			next_valid = hsv_valid;
			if (hsv_valid && !hsv_stall) begin
				rgb_expected.push_back(hsv_to_rgb_ref(hue_in, saturation_in, value_in));
				n_sent++;
				next_valid = 1'b0;
			end
			if (!next_valid && hsv_pending.size() != 0) begin
				if (!armed) begin
					wait_left = hsv_pending[0].gap;
					armed = 1'b1;
				end
				if (wait_left == 0) begin
					cur = hsv_pending.pop_front();
					armed = 1'b0;
					hue_in        <= cur.hue;
					saturation_in <= cur.sat;
					value_in      <= cur.val;
					next_valid = 1'b1;
				end else begin
					wait_left--;
				end
			end
			// idle cycles carry junk on the data lines
			if (!next_valid) begin
				hue_in        <= 8'($urandom);
				saturation_in <= 8'($urandom);
				value_in      <= 8'($urandom);
			end
			hsv_valid <= next_valid;
		end
	end

	// Output monitor: stall drawn per result, compare against oldest expectation
	always @(posedge clk or negedge arst_n) begin : collect
		int unsigned stall_left;
		int unsigned stall_mode;
		rgb_t        got;
		rgb_t        want;
		if (!arst_n) begin
			rgb_stall <= 1'b0;
			stall_left = 0;
			stall_mode = PACE_NONE;
		end else begin
			if (rgb_valid && !rgb_stall) begin
				got.red   = red_out;
				got.green = green_out;
				got.blue  = blue_out;
				n_results++;
				if (rgb_expected.size() == 0) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("ERROR: unexpected transfer r=%0d g=%0d b=%0d at cycle %0d",
							got.red, got.green, got.blue, n_cycles);
				end else begin
					want = rgb_expected.pop_front();
					if (got.red !== want.red || got.green !== want.green
							|| got.blue !== want.blue) begin
						n_errors++;
						if (n_errors <= MAX_REPORTS)
							$display("ERROR: result %0d expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
								n_results, want.red, want.green, want.blue,
								got.red, got.green, got.blue);
					end
				end
				// switch stall pattern now and then
				if (n_results % 150 == 0)
					stall_mode = $urandom_range(PACE_NONE, PACE_RARE);
				stall_left = draw_wait(stall_mode);
			end else if (stall_left != 0) begin
				stall_left--;
			end
			rgb_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d sent, %0d results",
				n_cycles, n_sent, n_items, n_results);
			$display("hsv_to_rgb_converter: mismatch");
			$finish;
		end
	end

	initial begin : main
		int unsigned pace;
		// extremes, saturating inputs, sector boundaries, hue at 360 degrees
		add_item(8'd0,   8'd0,   8'd0,   0);
		add_item(8'd254, 8'd254, 8'd254, 0);
		add_item(8'd255, 8'd255, 8'd255, 0);
		add_item(8'd0,   8'd254, 8'd254, 0);
		add_item(8'd42,  8'd254, 8'd254, 0);
		add_item(8'd43,  8'd254, 8'd254, 0);
		add_item(8'd84,  8'd254, 8'd254, 3);
		add_item(8'd85,  8'd254, 8'd254, 0);
		add_item(8'd127, 8'd254, 8'd254, 0);
		add_item(8'd128, 8'd254, 8'd200, 0);
		add_item(8'd169, 8'd254, 8'd254, 1);
		add_item(8'd170, 8'd254, 8'd254, 0);
		add_item(8'd211, 8'd254, 8'd254, 0);
		add_item(8'd212, 8'd254, 8'd254, 0);
		add_item(8'd253, 8'd254, 8'd254, 0);
		add_item(8'd254, 8'd254, 8'd100, 0);
		add_item(8'd255, 8'd128, 8'd254, 5);
		add_item(8'd100, 8'd0,   8'd254, 0);
		add_item(8'd100, 8'd254, 8'd0,   0);
		add_item(8'd100, 8'd255, 8'd255, 0);
		add_item(8'd30,  8'd255, 8'd1,   0);
		add_item(8'd1,   8'd1,   8'd1,   0);
		add_item(8'd200, 8'd128, 8'd128, 0);
		add_item(8'd85,  8'd100, 8'd255, 0);
		n_directed = hsv_pending.size();

		pace = PACE_NONE;
		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 150 == 0)
				pace = $urandom_range(PACE_NONE, PACE_RARE);
			add_item(pick_component(), pick_component(), pick_component(), draw_wait(pace));
		end
		n_items = hsv_pending.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (n_sent < n_items)
			@(posedge clk);
		while (rgb_expected.size() != 0)
			@(posedge clk);
		// catch any stray transfer after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d colors (%0d edge cases, %0d random) in %0d cycles,",
			n_results, n_directed, n_items - n_directed, n_cycles);
		$display("with input gaps, output stalls and components above full scale; %0d errors.",
			n_errors);
		if (n_errors == 0)
			$display("hsv_to_rgb_converter: match");
		else
			$display("hsv_to_rgb_converter: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_byte_scale.sv
hw/rtl/hsv_to_rgb_converter.sv
hw/rtl/hsvrgb_checker.sv
tb/sv/tb_hsv_to_rgb_converter.sv
